FILE: rtl/core/uidec_pkg.sv
// ----------------------------------------------------------------------------
// uidec_pkg
// Shared types and constants for the 32-bit decimal text converter.
// ----------------------------------------------------------------------------
package uidec_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_DIGITS = 10;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 6;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int PTR_W      = $clog2(NUM_DIGITS);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

   // controls broadcast to every digit cell
   typedef struct packed {
      logic clear;   // zero the digit
      logic shift;   // adjust and shift one bit in
   } uidec_cell_ctl_type;

endpackage

FILE: rtl/core/uidec_cell.sv
// ----------------------------------------------------------------------------
// uidec_cell
// One BCD digit of the shift-and-add-3 chain.
// ----------------------------------------------------------------------------
module uidec_cell
   import uidec_pkg::*;
(
   input  logic                 clock,
   input  uidec_cell_ctl_type   ctl,
   input  logic                 carry_in,   // bit from the lower neighbor
   output logic                 carry_out,  // bit to the upper neighbor
   output logic [DIGIT_W-1:0]   digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // add 3 when the digit would reach ten or more after doubling
   assign adj       = (digit_ff >= ADJ_LIMIT) ? DIGIT_W'(digit_ff + ADJ_ADD) : digit_ff;
   assign carry_out = adj[DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.shift) begin
         digit_in = {adj[DIGIT_W-2:0], carry_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

FILE: rtl/core/uint32_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// uint32_to_decimal_ascii_core
// Converts a 32-bit unsigned value into its decimal ASCII digits.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries a 32-bit unsigned value in req_tdata.
//   rsp channel: one beat per decimal digit, most significant first, leading
//   zeros suppressed; rsp_tlast marks the final (least significant) digit.
//   A value of zero yields the single character '0'.
// Timing:
//   After a beat is taken, a row of ten BCD digit cells runs the
//   shift-and-add-3 conversion, one value bit per cycle, over all 32 value
//   bits. A locate step then finds the most significant nonzero digit, and
//   digits go out one per cycle while rsp_tready does not stall them. A new
//   value is taken only once the last digit of the previous one is issued.
// Reset: synchronous, active high; drops the output beat and returns to idle.
// Stall: a held rsp_tready freezes digit emission; the output register holds
//   its beat. req_tready rises as soon as the last digit sits in the output
//   register, so the next value is taken while that digit waits.
// ----------------------------------------------------------------------------
module uint32_to_decimal_ascii_core
   import uidec_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [31:0] value

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [5:0] digit_char, [7:6] zero
   output logic                rsp_tlast    // last_digit
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LOCATE,
      ST_EMIT
   } state_type;

   state_type               state_ff, state_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [VALUE_W-1:0]      value_ff, value_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   uidec_cell_ctl_type      cell_ctl;
   logic [NUM_DIGITS-1:0]   carry;
   logic [DIGIT_W-1:0]      digit [NUM_DIGITS];
   logic [PTR_W-1:0]        msd_idx;
   logic                    out_free;
   logic                    req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign cell_ctl.clear = req_fire;
   assign cell_ctl.shift = (state_ff == ST_CONVERT);

   // digit chain: cell 0 takes the value MSB, each cell feeds the next
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      uidec_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .carry_in  ((i == 0) ? value_ff[VALUE_W-1] : carry[(i == 0) ? 0 : i-1]),
         .carry_out (carry[i]),
         .digit     (digit[i])
      );
   end

   // highest nonzero digit, zero value falls to digit 0
   always_comb begin
      msd_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (digit[i] != '0) begin
            msd_idx = PTR_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      ptr_in       = ptr_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               value_in   = req_tdata;
               bit_cnt_in = '0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            value_in   = {value_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = BIT_CNT_W'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_LOCATE;
            end
         end
         ST_LOCATE: begin
            ptr_in   = msd_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + CHAR_W'(digit[ptr_ff]);
               rsp_last_in  = (ptr_ff == '0);
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in = PTR_W'(ptr_ff - 1'b1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_cnt_ff  <= bit_cnt_in;
      ptr_ff      <= ptr_in;
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
